// ----- sv/priority_round_robin_selector_defines.svh -----
// Assertion macros shared by the selector modules
`ifndef PRIORITY_ROUND_ROBIN_SELECTOR_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define PRRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prrs assertion failed");
// check on every clock edge, reset included
`define PRRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prrs assertion failed");
`else
`define PRRS_ASSERT(lbl, prop)
`define PRRS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- sv/prrs_pkg.sv -----
package prrs_pkg;

  localparam int PRIORITY_LEVELS_DEF = 4;
  localparam int MAX_CANDIDATES_DEF  = 16;

  localparam int OWNER_W = 16;
  localparam int PRIO_W  = 3;
  localparam int INDEX_W = 4;

  localparam logic [OWNER_W-1:0] SENTINEL_OWNER = '1;

  typedef enum logic [1:0] {
    FUNC_CAND   = 2'd0,
    FUNC_EMPTY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_SELECTED   = 2'd0,
    STATUS_NONE_READY = 2'd1,
    STATUS_INVALID    = 2'd2,
    STATUS_TOO_MANY   = 2'd3
  } status_t;

  typedef struct packed {
    func_t               func;
    logic                ready_req;
    logic [PRIO_W-1:0]   priority_req;
    logic [OWNER_W-1:0]  owner;
    logic                last;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
  } out_item_t;

  typedef enum logic {
    ST_COLLECT = 1'b0,
    ST_CLOSE   = 1'b1
  } state_t;

  typedef struct packed {
    logic take;
    logic empty;
    logic wipe;
    logic close;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- sv/prrs_ctrl.sv -----
`include "priority_round_robin_selector_defines.svh"

module prrs_ctrl
  import prrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  func_t      in_func,
  input  logic       in_last,
  output logic       in_stall,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // stall every item in the close state; hold an empty round back while the output register cannot take it
  always_comb begin
    in_stall = (state_r == ST_CLOSE) ||
               (in_func == FUNC_EMPTY && !dp_status.out_free);
    accept   = in_valid && !in_stall;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (accept && in_func == FUNC_CAND && in_last) state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (dp_status.out_free) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_COLLECT: begin
        cmd.take  = accept && in_func == FUNC_CAND;
        cmd.empty = accept && in_func == FUNC_EMPTY;
        cmd.wipe  = accept && in_func == FUNC_CLEAR;
      end
      ST_CLOSE: begin
        cmd.close = dp_status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  `PRRS_ASSERT(a_one_cmd, $onehot0({cmd.take, cmd.empty, cmd.wipe, cmd.close}))
  `PRRS_ASSERT(a_last_closes, (cmd.take && in_last) |=> state_r == ST_CLOSE)
  `PRRS_ASSERT(a_close_waits, (state_r == ST_CLOSE && !dp_status.out_free) |=> state_r == ST_CLOSE)

endmodule

// ----- sv/prrs_dp.sv -----
`include "priority_round_robin_selector_defines.svh"

module prrs_dp
  import prrs_pkg::*;
#(
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
  parameter int MAX_CANDIDATES  = MAX_CANDIDATES_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t dp_status,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 2);
  localparam int LVL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_CANDIDATES);
  localparam logic [PRIO_W:0]   PRIO_LIM = (PRIO_W + 1)'(PRIORITY_LEVELS);

  logic [OWNER_W-1:0] rem_owner_r  [PRIORITY_LEVELS];
  logic [OWNER_W-1:0] rem_owner_nxt[PRIORITY_LEVELS];
  logic               rem_valid_r  [PRIORITY_LEVELS];
  logic               rem_valid_nxt[PRIORITY_LEVELS];
  logic [OWNER_W-1:0] above_owner_r  [PRIORITY_LEVELS];
  logic [OWNER_W-1:0] above_owner_nxt[PRIORITY_LEVELS];
  logic [INDEX_W-1:0] above_index_r  [PRIORITY_LEVELS];
  logic [INDEX_W-1:0] above_index_nxt[PRIORITY_LEVELS];
  logic [OWNER_W-1:0] min_owner_r  [PRIORITY_LEVELS];
  logic [OWNER_W-1:0] min_owner_nxt[PRIORITY_LEVELS];
  logic [INDEX_W-1:0] min_index_r  [PRIORITY_LEVELS];
  logic [INDEX_W-1:0] min_index_nxt[PRIORITY_LEVELS];
  logic               has_ready_r  [PRIORITY_LEVELS];
  logic               has_ready_nxt[PRIORITY_LEVELS];

  logic [CNT_W-1:0] round_count_r, round_count_nxt;
  logic             saw_invalid_r, saw_invalid_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CNT_W+INDEX_W-1:0] pos_wide;
  logic [INDEX_W-1:0]       pos_idx;
  logic                     in_range;
  logic                     prio_ok;
  logic                     any_ready;
  logic [LVL_W-1:0]         win_lvl;
  logic [OWNER_W-1:0]       win_owner;
  logic [INDEX_W-1:0]       win_index;
  out_item_t                close_item;

  assign dp_status.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the lowest ready level and its winner from the stored accumulators, and form the result status
  always_comb begin
    any_ready = 1'b0;
    win_lvl   = '0;
    for (int lv = PRIORITY_LEVELS - 1; lv >= 0; lv--) begin
      if (has_ready_r[lv]) begin
        any_ready = 1'b1;
        win_lvl   = LVL_W'(lv);
      end
    end
    win_owner = min_owner_r[0];
    win_index = min_index_r[0];
    for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
      if (win_lvl == LVL_W'(lv)) begin
        if (above_owner_r[lv] != SENTINEL_OWNER) begin
          win_owner = above_owner_r[lv];
          win_index = above_index_r[lv];
        end else begin
          win_owner = min_owner_r[lv];
          win_index = min_index_r[lv];
        end
      end
    end
    close_item.status = STATUS_NONE_READY;
    close_item.index  = '0;
    priority if (round_count_r > CNT_MAX) begin
      close_item.status = STATUS_TOO_MANY;
    end else if (saw_invalid_r) begin
      close_item.status = STATUS_INVALID;
    end else if (any_ready) begin
      close_item.status = STATUS_SELECTED;
      close_item.index  = win_index;
    end
  end

  always_comb begin
    pos_wide = (CNT_W + INDEX_W)'(round_count_r);
    pos_idx  = pos_wide[INDEX_W-1:0];
    in_range = round_count_r < CNT_MAX;
    prio_ok  = {1'b0, in_data.priority_req} < PRIO_LIM;

    round_count_nxt = round_count_r;
    saw_invalid_nxt = saw_invalid_r;
    for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
      rem_owner_nxt[lv]   = rem_owner_r[lv];
      rem_valid_nxt[lv]   = rem_valid_r[lv];
      above_owner_nxt[lv] = above_owner_r[lv];
      above_index_nxt[lv] = above_index_r[lv];
      min_owner_nxt[lv]   = min_owner_r[lv];
      min_index_nxt[lv]   = min_index_r[lv];
      has_ready_nxt[lv]   = has_ready_r[lv];
    end

    if (cmd.take) begin
      if (round_count_r <= CNT_MAX) round_count_nxt = round_count_r + 1'b1;
      // candidates past the limit only count
      if (in_range && !prio_ok) saw_invalid_nxt = 1'b1;
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        if (in_range && prio_ok && in_data.ready_req &&
            in_data.priority_req == PRIO_W'(lv)) begin
          if (!has_ready_r[lv] || in_data.owner < min_owner_r[lv]) begin
            min_owner_nxt[lv] = in_data.owner;
            min_index_nxt[lv] = pos_idx;
          end
          has_ready_nxt[lv] = 1'b1;
          if (rem_valid_r[lv] && in_data.owner > rem_owner_r[lv] &&
              in_data.owner < above_owner_r[lv]) begin
            above_owner_nxt[lv] = in_data.owner;
            above_index_nxt[lv] = pos_idx;
          end
        end
      end
    end

    if (cmd.close && close_item.status == STATUS_SELECTED) begin
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        if (win_lvl == LVL_W'(lv)) begin
          rem_owner_nxt[lv] = win_owner;
          rem_valid_nxt[lv] = 1'b1;
        end
      end
    end

    // drop the round after a result or a clear
    if (cmd.close || cmd.empty || cmd.wipe) begin
      round_count_nxt = '0;
      saw_invalid_nxt = 1'b0;
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        above_owner_nxt[lv] = SENTINEL_OWNER;
        above_index_nxt[lv] = '0;
        min_owner_nxt[lv]   = SENTINEL_OWNER;
        min_index_nxt[lv]   = '0;
        has_ready_nxt[lv]   = 1'b0;
      end
    end

    if (cmd.wipe) begin
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        rem_owner_nxt[lv] = '0;
        rem_valid_nxt[lv] = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.close) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = close_item;
    end else if (cmd.empty) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: STATUS_NONE_READY, index: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= '0;
      saw_invalid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        rem_owner_r[lv]   <= '0;
        rem_valid_r[lv]   <= 1'b0;
        above_owner_r[lv] <= SENTINEL_OWNER;
        above_index_r[lv] <= '0;
        min_owner_r[lv]   <= SENTINEL_OWNER;
        min_index_r[lv]   <= '0;
        has_ready_r[lv]   <= 1'b0;
      end
    end else begin
      round_count_r <= round_count_nxt;
      saw_invalid_r <= saw_invalid_nxt;
      out_valid_r   <= out_valid_nxt;
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
        rem_owner_r[lv]   <= rem_owner_nxt[lv];
        rem_valid_r[lv]   <= rem_valid_nxt[lv];
        above_owner_r[lv] <= above_owner_nxt[lv];
        above_index_r[lv] <= above_index_nxt[lv];
        min_owner_r[lv]   <= min_owner_nxt[lv];
        min_index_r[lv]   <= min_index_nxt[lv];
        has_ready_r[lv]   <= has_ready_nxt[lv];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `PRRS_ASSERT(a_close_loads, cmd.close |=> out_valid_r && round_count_r == '0)
  `PRRS_ASSERT(a_empty_status, cmd.empty |=> out_data_r.status == STATUS_NONE_READY)

endmodule

// ----- sv/priority_round_robin_selector.sv -----
// Flow: a closing candidate moves the control into the close state, which loads
// the result into the output register once it is free; an empty round loads the
// output register on acceptance. Throughput: 1 candidate per cycle while in_stall
// is low; input stalls in the close state resolving the per-level accumulators.
// Reset: synchronous, active low; clears rotation memory and round accumulators.
`include "priority_round_robin_selector_defines.svh"

module priority_round_robin_selector
  import prrs_pkg::*;
#(
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
  parameter int MAX_CANDIDATES  = MAX_CANDIDATES_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  prrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  prrs_dp #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .MAX_CANDIDATES  (MAX_CANDIDATES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .dp_status (dp_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb_priority_round_robin_selector.sv -----
module tb_priority_round_robin_selector;
  import prrs_pkg::*;

  localparam int LEVELS       = PRIORITY_LEVELS_DEF;
  localparam int MAX_CANDS    = MAX_CANDIDATES_DEF;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 6;
  localparam int STUCK_LIMIT  = 3000;
  localparam int SHOW_LIMIT   = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  priority_round_robin_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Rotation memory and round accumulators of the predictor
  logic [OWNER_W-1:0] mem_owner [LEVELS];
  bit                 mem_valid [LEVELS];
  int unsigned        cand_count;
  bit                 bad_prio;
  logic [OWNER_W-1:0] above_owner [LEVELS];
  logic [INDEX_W-1:0] above_idx [LEVELS];
  logic [OWNER_W-1:0] min_owner [LEVELS];
  logic [INDEX_W-1:0] min_idx [LEVELS];
  bit                 has_ready [LEVELS];

  out_item_t   pick_queue [$];
  int unsigned items_sent;
  int unsigned picks_checked;
  int unsigned status_seen [4];
  int unsigned fail_count;
  int unsigned stuck_cycles;

  bit          send_idle_on;
  bit          recv_idle_on;
  bit          hold_go;
  int unsigned hold_left;
  int unsigned stall_left;

  task automatic clear_round_acc();
    cand_count = 0;
    bad_prio   = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      above_owner[l] = SENTINEL_OWNER;
      above_idx[l]   = '0;
      min_owner[l]   = SENTINEL_OWNER;
      min_idx[l]     = '0;
      has_ready[l]   = 1'b0;
    end
  endtask

  task automatic clear_rotation();
    for (int l = 0; l < LEVELS; l++) begin
      mem_owner[l] = '0;
      mem_valid[l] = 1'b0;
    end
  endtask

  task automatic predict_pick(input in_item_t it);
    out_item_t          res;
    int unsigned        pos;
    int unsigned        lv;
    bit                 found;
    logic [OWNER_W-1:0] win;
    res.status = STATUS_NONE_READY;
    res.index  = '0;
    case (it.func)
      FUNC_EMPTY: begin
        clear_round_acc();
        pick_queue.push_back(res);
      end
      FUNC_CLEAR: begin
        clear_rotation();
        clear_round_acc();
      end
      FUNC_CAND: begin
        pos = cand_count;
        if (cand_count <= MAX_CANDS)
          cand_count++;
        // candidates past the limit only count toward the too-many check
        if (pos < MAX_CANDS) begin
          if (it.priority_req >= LEVELS) begin
            bad_prio = 1'b1;
          end else if (it.ready_req) begin
            lv = {29'd0, it.priority_req};
            if (!has_ready[lv] || it.owner < min_owner[lv]) begin
              has_ready[lv] = 1'b1;
              min_owner[lv] = it.owner;
              min_idx[lv]   = pos[INDEX_W-1:0];
            end
            if (mem_valid[lv] && it.owner > mem_owner[lv] && it.owner < above_owner[lv]) begin
              above_owner[lv] = it.owner;
              above_idx[lv]   = pos[INDEX_W-1:0];
            end
          end
        end
        if (it.last) begin
          found = 1'b0;
          if (cand_count > MAX_CANDS) begin
            res.status = STATUS_TOO_MANY;
          end else if (bad_prio) begin
            res.status = STATUS_INVALID;
          end else begin
            for (int l = 0; l < LEVELS; l++) begin
              if (has_ready[l] && !found) begin
                found = 1'b1;
                // the sentinel never counts as an owner above the remembered one
                if (above_owner[l] != SENTINEL_OWNER) begin
                  win       = above_owner[l];
                  res.index = above_idx[l];
                end else begin
                  win       = min_owner[l];
                  res.index = min_idx[l];
                end
                mem_owner[l] = win;
                mem_valid[l] = 1'b1;
                res.status   = STATUS_SELECTED;
              end
            end
          end
          pick_queue.push_back(res);
          clear_round_acc();
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t mk_cand(input bit rdy, input logic [PRIO_W-1:0] prio,
                                       input logic [OWNER_W-1:0] own, input bit is_last);
    in_item_t it;
    it.func         = FUNC_CAND;
    it.ready_req    = rdy;
    it.priority_req = prio;
    it.owner        = own;
    it.last         = is_last;
    return it;
  endfunction

  function automatic in_item_t mk_cmd(input func_t f);
    in_item_t it;
    it      = mk_cand(1'($urandom_range(0, 1)), PRIO_W'($urandom_range(0, 7)),
                      OWNER_W'($urandom()), 1'($urandom_range(0, 1)));
    it.func = f;
    return it;
  endfunction

  function automatic in_item_t rand_cand(input bit is_last);
    logic [PRIO_W-1:0]  prio;
    logic [OWNER_W-1:0] own;
    prio = ($urandom_range(0, 29) == 0) ? PRIO_W'($urandom_range(LEVELS, 7))
                                        : PRIO_W'($urandom_range(0, LEVELS - 1));
    // a small pool of owners makes the rotation visible
    case ($urandom_range(0, 9))
      0:       own = SENTINEL_OWNER;
      1, 2:    own = OWNER_W'($urandom());
      default: own = OWNER_W'($urandom_range(0, 7));
    endcase
    return mk_cand($urandom_range(0, 4) != 0, prio, own, is_last);
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pick(it);
    if (it.func != FUNC_UNUSED)
      items_sent++;
  endtask

  task automatic send_round(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_item(rand_cand(i == len - 1));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pick_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_empty_and_unused();
    send_item(mk_cmd(FUNC_EMPTY));
    send_item(mk_cmd(FUNC_UNUSED));
  endtask

  task automatic test_rotation();
    send_item(mk_cand(1'b1, 3'd0, 16'd5, 1'b0));
    send_item(mk_cand(1'b1, 3'd0, SENTINEL_OWNER, 1'b0));
    send_item(mk_cand(1'b1, 3'd1, 16'd0, 1'b1));
    // nothing above the remembered owner but the sentinel: wrap, first of equals
    send_item(mk_cand(1'b1, 3'd0, SENTINEL_OWNER, 1'b0));
    send_item(mk_cand(1'b1, 3'd0, 16'd3, 1'b0));
    send_item(mk_cand(1'b1, 3'd0, 16'd3, 1'b1));
    send_item(mk_cand(1'b1, 3'd0, 16'd7, 1'b0));
    send_item(mk_cand(1'b1, 3'd0, 16'd4, 1'b0));
    send_item(mk_cand(1'b1, 3'd0, 16'd9, 1'b1));
    // sentinel alone at its level
    send_item(mk_cand(1'b1, 3'd2, SENTINEL_OWNER, 1'b1));
  endtask

  task automatic test_status_order();
    send_item(mk_cand(1'b1, 3'd7, 16'd0, 1'b1));
    send_item(mk_cand(1'b0, 3'd3, SENTINEL_OWNER, 1'b1));
    send_item(mk_cand(1'b1, 3'd0, 16'd1, 1'b0));
    send_item(mk_cand(1'b1, 3'd4, 16'd2, 1'b1));
  endtask

  task automatic test_clear_and_abort();
    send_item(mk_cand(1'b1, 3'd0, 16'd9, 1'b0));
    send_item(mk_cmd(FUNC_CLEAR));
    send_item(mk_cand(1'b1, 3'd0, 16'd1, 1'b1));
    send_item(mk_cand(1'b1, 3'd0, 16'd2, 1'b0));
    send_item(mk_cmd(FUNC_EMPTY));
  endtask

  task automatic test_round_limit();
    for (int unsigned i = 0; i < MAX_CANDS - 1; i++)
      send_item(mk_cand(1'($urandom_range(0, 1)), 3'd1, OWNER_W'($urandom()), 1'b0));
    send_item(mk_cand(1'b1, 3'd0, OWNER_W'($urandom()), 1'b1));
    send_round(MAX_CANDS + 1);
    send_round(MAX_CANDS + 4);
  endtask

  task automatic test_random_rounds(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(0, 19))
        0: send_item(mk_cmd(FUNC_EMPTY));
        1: send_item(mk_cmd(FUNC_CLEAR));
        2: send_item(mk_cmd(FUNC_UNUSED));
        3: begin
          // broken round: drop it with a command before the closing candidate
          for (int unsigned i = $urandom_range(1, 4); i > 0; i--)
            send_item(rand_cand(1'b0));
          send_item(mk_cmd($urandom_range(0, 1) ? FUNC_EMPTY : FUNC_CLEAR));
        end
        4: send_round($urandom_range(10, MAX_CANDS + 2));
        default: send_round($urandom_range(1, 6));
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_on = 1'b0;
    hold_go      = 1'b1;
    for (int i = 0; i < 40; i++)
      send_round($urandom_range(1, 2));
    send_idle_on = 1'b1;
  endtask

  task automatic test_idle_drain();
    send_round(3);
    wait_drained();
    send_round(2);
    send_item(mk_cmd(FUNC_EMPTY));
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (recv_idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 14);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pick_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected result: status %0d index %0d", out_data.status, out_data.index);
      end else begin
        want = pick_queue.pop_front();
        picks_checked++;
        status_seen[want.status]++;
        if (out_data.status !== want.status || out_data.index !== want.index) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("result %0d: expected status %0d index %0d, got status %0d index %0d",
                     picks_checked, want.status, want.index, out_data.status, out_data.index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               stuck_cycles, pick_queue.size());
      $display("** priority_round_robin_selector: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    hold_go      = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    items_sent   = 0;
    fail_count   = 0;
    stuck_cycles = 0;
    clear_rotation();
    clear_round_acc();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_empty_and_unused();
    test_rotation();
    test_status_order();
    test_clear_and_abort();
    test_round_limit();
    test_random_rounds(200);
    test_output_backpressure();
    test_idle_drain();
    test_random_rounds(100);

    // last stretch at full rate on both sides
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random_rounds(100);
    wait_drained();

    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
             picks_checked, fail_count);
    $display("results by status: selected %0d, none ready %0d, invalid %0d, too many %0d",
             status_seen[STATUS_SELECTED], status_seen[STATUS_NONE_READY],
             status_seen[STATUS_INVALID], status_seen[STATUS_TOO_MANY]);
    if (fail_count == 0)
      $display("** priority_round_robin_selector: PASSED **");
    else
      $display("** priority_round_robin_selector: FAILED **");
    $finish;
  end

endmodule
